// ===== sv/table_interpolator_1d_2d_macros.svh =====
// Assertion macros for the table interpolator.
// Sampled on aclk, switched off while aresetn is low; no other dependencies.
`ifndef TABLE_INTERPOLATOR_1D_2D_MACROS_SVH
`define TABLE_INTERPOLATOR_1D_2D_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TINT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("table interpolator check failed");

// Consequent must hold in the cycle after the antecedent.
`define TINT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("table interpolator check failed");

`endif

// ===== sv/tint_pkg.sv =====
// Shared constants, types and helper functions of the table interpolator.
// Used by tint_lerp, tint_dp, tint_ctrl and the top level; depends on nothing.
`default_nettype none

package tint_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 16;
    localparam int DW       = 32;

    localparam int ROW_AW = $clog2(MAX_ROWS);
    localparam int COL_AW = $clog2(MAX_COLS);
    localparam int VAL_AW = $clog2(MAX_ROWS * MAX_COLS);
    localparam int ROW_CW = $clog2(MAX_ROWS + 2);
    localparam int COL_CW = $clog2(MAX_COLS + 2);
    localparam int IDX_W  = (ROW_CW > COL_CW) ? ROW_CW : COL_CW;

    localparam int TDATA_W = 3 * DW;

    localparam int CFG_IW = 2;
    localparam int CFG_DW = 7;

    localparam logic [CFG_IW-1:0] CFG_MODE = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_ROWS = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_COLS = 2'd2;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // Read slots: which table entries one read fetches and where they land
    typedef enum logic [2:0] {
        SL_LO, SL_HI, SL_SLO, SL_SHI, SL_A, SL_B, SL_C, SL_D
    } slot_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_CLAMP, OP_SINIT, OP_SDEC, OP_SINC, OP_SSAVE,
        OP_L1, OP_L2, OP_L3, OP_CAP_R1, OP_CAP_R2,
        OP_RES_LO, OP_RES_HI, OP_RES_LERP
    } op_t;

    typedef struct packed {
        op_t   op;
        logic  rd_en;
        slot_t rd_slot;
        logic  srch_col;
        logic  take_in;
    } cmd_t;

    typedef struct packed {
        logic two_dim;
        logic key_le_lo;
        logic key_ge_hi;
        logic idx_gt1;
        logic idx_lt_top;
        logic data_gt_key;
        logic data_lt_key;
        logic lerp_busy;
    } status_t;

    function automatic logic [VAL_AW-1:0] val_addr(input logic [ROW_CW-1:0] row,
                                                   input logic [COL_CW-1:0] col);
        return VAL_AW'(int'(row) * MAX_COLS + int'(col));
    endfunction

endpackage

`default_nettype wire

// ===== sv/tint_ram.sv =====
// Generic single-port RAM with registered read data.
// Stand-alone; used for the key and value stores of the table interpolator.
`default_nettype none

module tint_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire  logic                     aclk,
    input  wire  logic                     we,
    input  wire  logic [$clog2(DEPTH)-1:0] addr,
    input  wire  logic [WIDTH-1:0]         wdata,
    output logic       [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/tint_lerp.sv =====
// Interpolation unit: f1 + (f2 - f1) * (x - x1) / (x2 - x1), truncated, saturated.
// Bit-serial multiply then restoring divide; depends on tint_pkg.
`default_nettype none

module tint_lerp (
    input  wire  logic                       aclk,
    input  wire  logic                       aresetn,
    input  wire  logic                       start,
    input  wire  logic signed [tint_pkg::DW-1:0] x1,
    input  wire  logic signed [tint_pkg::DW-1:0] f1,
    input  wire  logic signed [tint_pkg::DW-1:0] x2,
    input  wire  logic signed [tint_pkg::DW-1:0] f2,
    input  wire  logic signed [tint_pkg::DW-1:0] x,
    output logic                             busy,
    output logic signed [tint_pkg::DW-1:0]   result
);

    localparam int MW = tint_pkg::DW + 1;
    localparam int PW = 2 * MW;
    localparam int QW = tint_pkg::DW + 3;
    localparam int SW = tint_pkg::DW + 5;
    localparam int CW = $clog2(PW);

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_MUL  = 4'b0010,
        L_DIV  = 4'b0100,
        L_FIN  = 4'b1000
    } lstate_t;

    lstate_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [PW-1:0] acc_reg, ash_reg;
    logic [MW-1:0] bsh_reg, den_reg;
    logic [MW:0]   rem_reg;
    logic          neg_reg;
    logic signed [tint_pkg::DW-1:0] f1_reg, res_reg;

    logic signed [MW-1:0] den_s, df_s, dx_s;
    logic [MW:0]   trial;
    logic          fits;
    logic [QW-1:0] qcap;
    logic signed [SW-1:0] sum;

    function automatic logic [MW-1:0] mag(input logic signed [MW-1:0] v);
        return v[MW-1] ? MW'(-v) : MW'(v);
    endfunction

    assign den_s = MW'(x2) - MW'(x1);
    assign df_s  = MW'(f2) - MW'(f1);
    assign dx_s  = MW'(x) - MW'(x1);

    assign trial = {rem_reg[MW-1:0], acc_reg[PW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    // Cap the quotient at 2^(DW+2) before the signed add
    always_comb begin
        if ((|acc_reg[PW-1:QW]) || (acc_reg[QW-1] && (|acc_reg[QW-2:0]))) begin
            qcap = QW'(1) << (QW - 1);
        end else begin
            qcap = acc_reg[QW-1:0];
        end
        sum = neg_reg ? (SW'(f1_reg) - SW'({1'b0, qcap}))
                      : (SW'(f1_reg) + SW'({1'b0, qcap}));
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            L_IDLE: begin
                if (start && (den_s != '0)) begin
                    state_next = L_MUL;
                    cnt_next   = '0;
                end
            end
            L_MUL: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(MW - 1)) begin
                    state_next = L_DIV;
                    cnt_next   = '0;
                end
            end
            L_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(PW - 1)) begin
                    state_next = L_FIN;
                end
            end
            L_FIN: begin
                state_next = L_IDLE;
            end
            default: begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            L_IDLE: begin
                if (start) begin
                    f1_reg  <= f1;
                    res_reg <= f1;
                    neg_reg <= df_s[MW-1] ^ dx_s[MW-1] ^ den_s[MW-1];
                    ash_reg <= PW'(mag(df_s));
                    bsh_reg <= mag(dx_s);
                    den_reg <= mag(den_s);
                    acc_reg <= '0;
                    rem_reg <= '0;
                end
            end
            L_MUL: begin
                if (bsh_reg[0]) begin
                    acc_reg <= acc_reg + ash_reg;
                end
                ash_reg <= ash_reg << 1;
                bsh_reg <= bsh_reg >> 1;
            end
            L_DIV: begin
                rem_reg <= fits ? (trial - {1'b0, den_reg}) : trial;
                acc_reg <= {acc_reg[PW-2:0], fits};
            end
            L_FIN: begin
                if (sum > SW'(32'sh7FFF_FFFF)) begin
                    res_reg <= 32'sh7FFF_FFFF;
                end else if (sum < -SW'(33'sh0_8000_0000)) begin
                    res_reg <= 32'sh8000_0000;
                end else begin
                    res_reg <= tint_pkg::DW'(sum);
                end
            end
            default: begin
                res_reg <= res_reg;
            end
        endcase
    end

    assign busy   = (state_reg != L_IDLE);
    assign result = res_reg;

endmodule

`default_nettype wire

// ===== sv/tint_dp.sv =====
// Datapath of the table interpolator: registers, table stores, search index, lerp unit.
// Driven by tint_ctrl commands; depends on tint_pkg, tint_ram and tint_lerp.
`default_nettype none

module tint_dp (
    input  wire  logic                          aclk,
    input  wire  logic                          aresetn,
    input  wire  logic                          cfg_valid,
    input  wire  logic [tint_pkg::CFG_IW-1:0]   cfg_index,
    input  wire  logic [tint_pkg::CFG_DW-1:0]   cfg_data,
    input  wire  logic [tint_pkg::TDATA_W-1:0]  s_tdata,
    input  wire  tint_pkg::cmd_t                cmd,
    output tint_pkg::status_t                   status,
    output logic [tint_pkg::DW-1:0]             m_tdata
);

    localparam int DW     = tint_pkg::DW;
    localparam int ROW_AW = tint_pkg::ROW_AW;
    localparam int COL_AW = tint_pkg::COL_AW;
    localparam int VAL_AW = tint_pkg::VAL_AW;
    localparam int ROW_CW = tint_pkg::ROW_CW;
    localparam int COL_CW = tint_pkg::COL_CW;
    localparam int IDX_W  = tint_pkg::IDX_W;

    // Configuration and cursor state
    logic              mode_reg, mode_next;
    logic [ROW_CW-1:0] rows_reg, rows_next;
    logic [COL_CW-1:0] cols_reg, cols_next;
    logic [ROW_CW-1:0] lrow_reg, lrow_next;
    logic [COL_CW-1:0] lcol_reg, lcol_next;
    logic [ROW_CW-1:0] crow_reg, crow_next;
    logic [COL_CW-1:0] ccol_reg, ccol_next;
    logic [IDX_W-1:0]  sidx_reg, sidx_next;
    logic [ROW_CW-1:0] r_reg, r_next;
    logic [COL_CW-1:0] c_reg, c_next;

    // Payload registers
    logic signed [DW-1:0] word_reg, kx_reg, ky_reg;
    logic signed [DW-1:0] rlo_reg, rhi_reg, clo_reg, chi_reg, flo_reg, fhi_reg;
    logic signed [DW-1:0] sdat_reg, x1_reg, x2_reg, y1_reg, y2_reg;
    logic signed [DW-1:0] v11_reg, v21_reg, v12_reg, v22_reg, r1_reg, out_reg;
    logic                 pend_reg, psel_reg;
    tint_pkg::slot_t      pslot_reg;

    logic                 rk_we, ck_we, v_we;
    logic [ROW_AW-1:0]    rk_waddr, rk_raddr, rk_addr;
    logic [COL_AW-1:0]    ck_waddr, ck_raddr, ck_addr;
    logic [VAL_AW-1:0]    v_waddr, v_raddr, v_addr;
    logic signed [DW-1:0] rk_rd, ck_rd, v_rd;

    logic [COL_CW:0]      cinc;
    logic [IDX_W-1:0]     nsel, cache_sel;
    logic [COL_CW-1:0]    ca, cb;
    logic [ROW_CW-1:0]    rm1;
    logic signed [DW-1:0] skey, tx, ty;

    logic                 lerp_start, lerp_busy;
    logic signed [DW-1:0] lx1, lf1, lx2, lf2, lx, lres;

    logic [CFG_DWX-1:0]   unused_c;
    localparam int CFG_DWX = 1;
    assign unused_c = '0;

    assign rm1  = r_reg - 1'b1;
    assign ca   = mode_reg ? (c_reg - 1'b1) : '0;
    assign cb   = ca + 1'b1;
    assign nsel = cmd.srch_col ? IDX_W'(cols_reg) : IDX_W'(rows_reg);
    assign cache_sel = cmd.srch_col ? IDX_W'(ccol_reg) : IDX_W'(crow_reg);
    assign skey = cmd.srch_col ? ky_reg : kx_reg;
    assign cinc = {1'b0, lcol_reg} + 1'b1;

    // Table load: append one word at the cursor; words beyond the table are ignored
    always_comb begin
        lrow_next = lrow_reg;
        lcol_next = lcol_reg;
        rk_we     = 1'b0;
        ck_we     = 1'b0;
        v_we      = 1'b0;
        rk_waddr  = ROW_AW'(lrow_reg);
        ck_waddr  = COL_AW'(lcol_reg);
        v_waddr   = tint_pkg::val_addr(lrow_reg, '0);
        if (cmd.op == tint_pkg::OP_LOAD) begin
            if (!mode_reg) begin
                if (lrow_reg < rows_reg) begin
                    if (lcol_reg == '0) begin
                        rk_we     = 1'b1;
                        lcol_next = COL_CW'(1);
                    end else begin
                        v_we      = 1'b1;
                        lcol_next = '0;
                        lrow_next = lrow_reg + 1'b1;
                    end
                end
            end else if (lrow_reg == '0) begin
                if (lcol_reg >= cols_reg) begin
                    lcol_next = '0;
                    lrow_next = ROW_CW'(1);
                end else begin
                    ck_we = 1'b1;
                    if (cinc >= {1'b0, cols_reg}) begin
                        lcol_next = '0;
                        lrow_next = ROW_CW'(1);
                    end else begin
                        lcol_next = COL_CW'(cinc);
                    end
                end
            end else if (lrow_reg <= rows_reg) begin
                rk_waddr = ROW_AW'(lrow_reg - 1'b1);
                v_waddr  = tint_pkg::val_addr(lrow_reg - 1'b1, lcol_reg - 1'b1);
                if (lcol_reg == '0) begin
                    rk_we = 1'b1;
                end else if (lcol_reg <= cols_reg) begin
                    v_we = 1'b1;
                end
                if (cinc > {1'b0, cols_reg}) begin
                    lcol_next = '0;
                    lrow_next = lrow_reg + 1'b1;
                end else begin
                    lcol_next = COL_CW'(cinc);
                end
            end
        end
    end

    // Read addresses per slot
    always_comb begin
        rk_raddr = '0;
        ck_raddr = '0;
        v_raddr  = '0;
        case (cmd.rd_slot)
            tint_pkg::SL_LO: begin
                rk_raddr = '0;
            end
            tint_pkg::SL_HI: begin
                rk_raddr = ROW_AW'(rows_reg - 1'b1);
                ck_raddr = COL_AW'(cols_reg - 1'b1);
                v_raddr  = tint_pkg::val_addr(rows_reg - 1'b1, '0);
            end
            tint_pkg::SL_SLO: begin
                rk_raddr = ROW_AW'(sidx_reg - 1'b1);
                ck_raddr = COL_AW'(sidx_reg - 1'b1);
            end
            tint_pkg::SL_SHI: begin
                rk_raddr = ROW_AW'(sidx_reg);
                ck_raddr = COL_AW'(sidx_reg);
            end
            tint_pkg::SL_A: begin
                rk_raddr = ROW_AW'(rm1);
                ck_raddr = COL_AW'(c_reg - 1'b1);
                v_raddr  = tint_pkg::val_addr(rm1, ca);
            end
            tint_pkg::SL_B: begin
                rk_raddr = ROW_AW'(r_reg);
                ck_raddr = COL_AW'(c_reg);
                v_raddr  = tint_pkg::val_addr(r_reg, ca);
            end
            tint_pkg::SL_C: begin
                v_raddr = tint_pkg::val_addr(rm1, cb);
            end
            tint_pkg::SL_D: begin
                v_raddr = tint_pkg::val_addr(r_reg, cb);
            end
            default: begin
                rk_raddr = '0;
            end
        endcase
    end

    assign rk_addr = rk_we ? rk_waddr : rk_raddr;
    assign ck_addr = ck_we ? ck_waddr : ck_raddr;
    assign v_addr  = v_we  ? v_waddr  : v_raddr;

    tint_ram #(.WIDTH(DW), .DEPTH(tint_pkg::MAX_ROWS)) u_rk_ram (
        .aclk (aclk), .we (rk_we), .addr (rk_addr), .wdata (word_reg), .rdata (rk_rd)
    );

    tint_ram #(.WIDTH(DW), .DEPTH(tint_pkg::MAX_COLS)) u_ck_ram (
        .aclk (aclk), .we (ck_we), .addr (ck_addr), .wdata (word_reg), .rdata (ck_rd)
    );

    tint_ram #(.WIDTH(DW), .DEPTH(tint_pkg::MAX_ROWS * tint_pkg::MAX_COLS)) u_v_ram (
        .aclk (aclk), .we (v_we), .addr (v_addr), .wdata (word_reg), .rdata (v_rd)
    );

    // Search index and cached indices
    always_comb begin
        sidx_next = sidx_reg;
        crow_next = crow_reg;
        ccol_next = ccol_reg;
        r_next    = r_reg;
        c_next    = c_reg;
        case (cmd.op)
            tint_pkg::OP_SINIT: begin
                sidx_next = cache_sel;
                if (cache_sel < IDX_W'(1)) begin
                    sidx_next = IDX_W'(1);
                end
                if (cache_sel > nsel - 1'b1) begin
                    sidx_next = nsel - 1'b1;
                end
            end
            tint_pkg::OP_SDEC: begin
                sidx_next = sidx_reg - 1'b1;
            end
            tint_pkg::OP_SINC: begin
                sidx_next = sidx_reg + 1'b1;
            end
            tint_pkg::OP_SSAVE: begin
                if (cmd.srch_col) begin
                    ccol_next = COL_CW'(sidx_reg);
                    c_next    = COL_CW'(sidx_reg);
                end else begin
                    crow_next = ROW_CW'(sidx_reg);
                    r_next    = ROW_CW'(sidx_reg);
                end
            end
            default: begin
                sidx_next = sidx_reg;
            end
        endcase
    end

    // Register writes: clamp counts (column count from cfg_data[4:0]), then restart cursors and caches
    always_comb begin
        mode_next = mode_reg;
        rows_next = rows_reg;
        cols_next = cols_reg;
        case (cfg_index)
            tint_pkg::CFG_MODE: begin
                mode_next = cfg_data[0];
            end
            tint_pkg::CFG_ROWS: begin
                if (cfg_data < 7'd2) begin
                    rows_next = ROW_CW'(2);
                end else if (int'(cfg_data) > tint_pkg::MAX_ROWS) begin
                    rows_next = ROW_CW'(tint_pkg::MAX_ROWS);
                end else begin
                    rows_next = ROW_CW'(cfg_data);
                end
            end
            tint_pkg::CFG_COLS: begin
                if (cfg_data[4:0] < 5'd2) begin
                    cols_next = COL_CW'(2);
                end else if (int'(cfg_data[4:0]) > tint_pkg::MAX_COLS) begin
                    cols_next = COL_CW'(tint_pkg::MAX_COLS);
                end else begin
                    cols_next = COL_CW'(cfg_data[4:0]);
                end
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            rows_reg <= ROW_CW'(2);
            cols_reg <= COL_CW'(2);
            lrow_reg <= '0;
            lcol_reg <= '0;
            crow_reg <= ROW_CW'(1);
            ccol_reg <= COL_CW'(1);
            sidx_reg <= IDX_W'(1);
            r_reg    <= ROW_CW'(1);
            c_reg    <= COL_CW'(1);
            pend_reg <= 1'b0;
        end else begin
            sidx_reg <= sidx_next;
            r_reg    <= r_next;
            c_reg    <= c_next;
            pend_reg <= cmd.rd_en;
            if (cfg_valid && (cfg_index == tint_pkg::CFG_MODE || cfg_index == tint_pkg::CFG_ROWS
                              || cfg_index == tint_pkg::CFG_COLS)) begin
                mode_reg <= mode_next;
                rows_reg <= rows_next;
                cols_reg <= cols_next;
                lrow_reg <= '0;
                lcol_reg <= '0;
                crow_reg <= ROW_CW'(1);
                ccol_reg <= COL_CW'(1);
            end else begin
                lrow_reg <= lrow_next;
                lcol_reg <= lcol_next;
                crow_reg <= crow_next;
                ccol_reg <= ccol_next;
            end
        end
    end

    // Clamp keys into the end breakpoints
    assign tx = (kx_reg < rlo_reg) ? rlo_reg : kx_reg;
    assign ty = (ky_reg < clo_reg) ? clo_reg : ky_reg;

    always_ff @(posedge aclk) begin
        pslot_reg <= cmd.rd_slot;
        psel_reg  <= cmd.srch_col;
        if (cmd.take_in) begin
            word_reg <= s_tdata[DW-1:0];
            kx_reg   <= s_tdata[2*DW-1:DW];
            ky_reg   <= s_tdata[3*DW-1:2*DW];
        end else if (cmd.op == tint_pkg::OP_CLAMP) begin
            kx_reg <= (tx > rhi_reg) ? rhi_reg : tx;
            ky_reg <= (ty > chi_reg) ? chi_reg : ty;
        end
        if (pend_reg) begin
            case (pslot_reg)
                tint_pkg::SL_LO: begin
                    rlo_reg <= rk_rd;
                    clo_reg <= ck_rd;
                    flo_reg <= v_rd;
                end
                tint_pkg::SL_HI: begin
                    rhi_reg <= rk_rd;
                    chi_reg <= ck_rd;
                    fhi_reg <= v_rd;
                end
                tint_pkg::SL_A: begin
                    x1_reg  <= rk_rd;
                    y1_reg  <= ck_rd;
                    v11_reg <= v_rd;
                end
                tint_pkg::SL_B: begin
                    x2_reg  <= rk_rd;
                    y2_reg  <= ck_rd;
                    v21_reg <= v_rd;
                end
                tint_pkg::SL_C: begin
                    v12_reg <= v_rd;
                end
                tint_pkg::SL_D: begin
                    v22_reg <= v_rd;
                end
                default: begin
                    sdat_reg <= psel_reg ? ck_rd : rk_rd;
                end
            endcase
        end
        case (cmd.op)
            tint_pkg::OP_CAP_R1:   r1_reg  <= lres;
            tint_pkg::OP_CAP_R2:   v12_reg <= lres;
            tint_pkg::OP_RES_LO:   out_reg <= flo_reg;
            tint_pkg::OP_RES_HI:   out_reg <= fhi_reg;
            tint_pkg::OP_RES_LERP: out_reg <= lres;
            default:               out_reg <= out_reg;
        endcase
    end

    // Interpolation operands; the second row result reuses v12 once L2 is done
    always_comb begin
        lerp_start = 1'b0;
        lx1 = x1_reg;
        lf1 = v11_reg;
        lx2 = x2_reg;
        lf2 = v21_reg;
        lx  = kx_reg;
        case (cmd.op)
            tint_pkg::OP_L1: begin
                lerp_start = 1'b1;
            end
            tint_pkg::OP_L2: begin
                lerp_start = 1'b1;
                lf1 = v12_reg;
                lf2 = v22_reg;
            end
            tint_pkg::OP_L3: begin
                lerp_start = 1'b1;
                lx1 = y1_reg;
                lf1 = r1_reg;
                lx2 = y2_reg;
                lf2 = v12_reg;
                lx  = ky_reg;
            end
            default: begin
                lerp_start = 1'b0;
            end
        endcase
    end

    tint_lerp u_lerp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lerp_start),
        .x1      (lx1),
        .f1      (lf1),
        .x2      (lx2),
        .f2      (lf2),
        .x       (lx),
        .busy    (lerp_busy),
        .result  (lres)
    );

    assign status.two_dim     = mode_reg;
    assign status.key_le_lo   = (kx_reg <= rlo_reg) | (|unused_c);
    assign status.key_ge_hi   = (kx_reg >= rhi_reg);
    assign status.idx_gt1     = (sidx_reg > IDX_W'(1));
    assign status.idx_lt_top  = (sidx_reg < nsel - 1'b1);
    assign status.data_gt_key = (sdat_reg > skey);
    assign status.data_lt_key = (sdat_reg < skey);
    assign status.lerp_busy   = lerp_busy;

    assign m_tdata = out_reg;

endmodule

`default_nettype wire

// ===== sv/tint_ctrl.sv =====
// Controller of the table interpolator: sequences loads, searches, fetches and lerps.
// Issues tint_pkg::cmd_t to tint_dp and reads its status; depends on tint_pkg.
`default_nettype none
`include "table_interpolator_1d_2d_macros.svh"

module tint_ctrl (
    input  wire  logic               aclk,
    input  wire  logic               aresetn,
    input  wire  logic               s_tvalid,
    output logic                     s_tready,
    input  wire  logic               s_tuser,
    output logic                     m_tvalid,
    input  wire  logic               m_tready,
    input  wire  tint_pkg::status_t  status,
    output tint_pkg::cmd_t           cmd
);

    typedef enum logic [18:0] {
        ST_IDLE   = 19'h00001,
        ST_LOAD   = 19'h00002,
        ST_END_LO = 19'h00004,
        ST_END_HI = 19'h00008,
        ST_END_W  = 19'h00010,
        ST_EDGE   = 19'h00020,
        ST_SINIT  = 19'h00040,
        ST_DN     = 19'h00080,
        ST_DN_W   = 19'h00100,
        ST_DN_C   = 19'h00200,
        ST_UP     = 19'h00400,
        ST_UP_W   = 19'h00800,
        ST_UP_C   = 19'h01000,
        ST_SAVE   = 19'h02000,
        ST_FETCH  = 19'h04000,
        ST_FETCH_W = 19'h08000,
        ST_LERP   = 19'h10000,
        ST_LWAIT  = 19'h20000,
        ST_RESULT = 19'h40000
    } state_t;

    state_t         state_reg, state_next;
    logic           sel_reg, sel_next;
    logic [1:0]     fc_reg, fc_next;
    logic [1:0]     ph_reg, ph_next;
    tint_pkg::op_t  res_op_reg, res_op_next;
    logic           mvalid_reg, mvalid_next;
    logic           out_free;

    assign out_free = !mvalid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        fc_next      = fc_reg;
        ph_next      = ph_reg;
        res_op_next  = res_op_reg;
        mvalid_next  = mvalid_reg && !m_tready;
        cmd.op       = tint_pkg::OP_NONE;
        cmd.rd_en    = 1'b0;
        cmd.rd_slot  = tint_pkg::SL_LO;
        cmd.srch_col = sel_reg;
        cmd.take_in  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cmd.take_in = s_tvalid;
                if (s_tvalid) begin
                    state_next = (s_tuser == tint_pkg::FUNC_LOOKUP) ? ST_END_LO : ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.op     = tint_pkg::OP_LOAD;
                state_next = ST_IDLE;
            end
            ST_END_LO: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_END_HI;
            end
            ST_END_HI: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_slot = tint_pkg::SL_HI;
                state_next  = ST_END_W;
            end
            ST_END_W: begin
                state_next = ST_EDGE;
            end
            ST_EDGE: begin
                sel_next = 1'b0;
                if (status.two_dim) begin
                    cmd.op     = tint_pkg::OP_CLAMP;
                    state_next = ST_SINIT;
                end else if (status.key_le_lo) begin
                    res_op_next = tint_pkg::OP_RES_LO;
                    state_next  = ST_RESULT;
                end else if (status.key_ge_hi) begin
                    res_op_next = tint_pkg::OP_RES_HI;
                    state_next  = ST_RESULT;
                end else begin
                    state_next = ST_SINIT;
                end
            end
            ST_SINIT: begin
                cmd.op     = tint_pkg::OP_SINIT;
                state_next = ST_DN;
            end
            ST_DN: begin
                if (status.idx_gt1) begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_slot = tint_pkg::SL_SLO;
                    state_next  = ST_DN_W;
                end else begin
                    state_next = ST_UP;
                end
            end
            ST_DN_W: begin
                state_next = ST_DN_C;
            end
            ST_DN_C: begin
                if (status.data_gt_key) begin
                    cmd.op     = tint_pkg::OP_SDEC;
                    state_next = ST_DN;
                end else begin
                    state_next = ST_UP;
                end
            end
            ST_UP: begin
                if (status.idx_lt_top) begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_slot = tint_pkg::SL_SHI;
                    state_next  = ST_UP_W;
                end else begin
                    state_next = ST_SAVE;
                end
            end
            ST_UP_W: begin
                state_next = ST_UP_C;
            end
            ST_UP_C: begin
                if (status.data_lt_key) begin
                    cmd.op     = tint_pkg::OP_SINC;
                    state_next = ST_UP;
                end else begin
                    state_next = ST_SAVE;
                end
            end
            ST_SAVE: begin
                cmd.op = tint_pkg::OP_SSAVE;
                if (status.two_dim && !sel_reg) begin
                    sel_next   = 1'b1;
                    state_next = ST_SINIT;
                end else begin
                    fc_next    = 2'd0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                cmd.rd_en = 1'b1;
                case (fc_reg)
                    2'd0:    cmd.rd_slot = tint_pkg::SL_A;
                    2'd1:    cmd.rd_slot = tint_pkg::SL_B;
                    2'd2:    cmd.rd_slot = tint_pkg::SL_C;
                    default: cmd.rd_slot = tint_pkg::SL_D;
                endcase
                fc_next = fc_reg + 1'b1;
                if (fc_reg == 2'd3) begin
                    state_next = ST_FETCH_W;
                end
            end
            ST_FETCH_W: begin
                ph_next    = 2'd1;
                state_next = ST_LERP;
            end
            ST_LERP: begin
                case (ph_reg)
                    2'd1:    cmd.op = tint_pkg::OP_L1;
                    2'd2:    cmd.op = tint_pkg::OP_L2;
                    default: cmd.op = tint_pkg::OP_L3;
                endcase
                state_next = ST_LWAIT;
            end
            ST_LWAIT: begin
                if (!status.lerp_busy) begin
                    if (status.two_dim && ph_reg == 2'd1) begin
                        cmd.op     = tint_pkg::OP_CAP_R1;
                        ph_next    = 2'd2;
                        state_next = ST_LERP;
                    end else if (status.two_dim && ph_reg == 2'd2) begin
                        cmd.op     = tint_pkg::OP_CAP_R2;
                        ph_next    = 2'd3;
                        state_next = ST_LERP;
                    end else begin
                        res_op_next = tint_pkg::OP_RES_LERP;
                        state_next  = ST_RESULT;
                    end
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    cmd.op      = res_op_reg;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            sel_reg    <= 1'b0;
            fc_reg     <= 2'd0;
            ph_reg     <= 2'd1;
            res_op_reg <= tint_pkg::OP_RES_LERP;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sel_reg    <= sel_next;
            fc_reg     <= fc_next;
            ph_reg     <= ph_next;
            res_op_reg <= res_op_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;

    `TINT_ASSERT_NOW(a_lerp_free, (cmd.op == tint_pkg::OP_L1 || cmd.op == tint_pkg::OP_L2 || cmd.op == tint_pkg::OP_L3), !status.lerp_busy)
    `TINT_ASSERT_NOW(a_out_free, (cmd.op == tint_pkg::OP_RES_LO || cmd.op == tint_pkg::OP_RES_HI || cmd.op == tint_pkg::OP_RES_LERP), out_free)
    `TINT_ASSERT_NEXT(a_lookup_start, (s_tvalid && s_tready && s_tuser == tint_pkg::FUNC_LOOKUP), (state_reg == ST_END_LO))

endmodule

`default_nettype wire

// ===== sv/table_interpolator_1d_2d.sv =====
// Top level of the breakpoint table interpolator (1D linear / 2D bilinear, Q16.16).
// Joins tint_ctrl and tint_dp; depends on tint_pkg.
//
// Usage:
//   Input stream (s_*): one transaction per item. s_tuser = 0 appends s_tdata
//   load_word to the table at the load cursor (row-major order); s_tuser = 1 is
//   a lookup of row_key (and col_key in 2D mode). Only lookups produce a result.
//   Result stream (m_*): m_tdata carries result_value, one transaction per lookup.
//   Config channel (cfg_*): index 0 mode, 1 row count, 2 column count. Always
//   ready; write only while the block is idle. A write to index 0, 1 or 2 rewinds the load cursor.
// Sequencing (one item at a time; s_tready is high only between items):
//   load: the word is written at the cursor. 1D lookup at or beyond an end key:
//   both end entries are read and the end value is returned. 1D lookup inside
//   the table: a key search, an entry fetch and one interpolation step. 2D lookup:
//   row and column searches, a fetch and three interpolation steps. Each step runs
//   the shared lerp unit: a shift-add multiply followed by a restoring divide; the
//   search reads one stored key at a time through the registered key memories.
// Reset (aresetn low, synchronous): 1D mode, 2 rows, 2 columns, cursors to zero,
//   cached indices to one, no result pending. Table contents are not cleared.
// Stall: a finished result waits in the output register while m_tready is low;
//   the next item is taken meanwhile, and its result waits until the slot frees.
`default_nettype none

module table_interpolator_1d_2d (
    input  wire  logic                          aclk,
    input  wire  logic                          aresetn,
    // s_tdata: load_word [31:0], row_key [63:32], col_key [95:64]
    input  wire  logic [tint_pkg::TDATA_W-1:0]  s_tdata,
    // s_tuser: func [0]
    input  wire  logic                          s_tuser,
    input  wire  logic                          s_tvalid,
    output logic                                s_tready,
    // m_tdata: result_value [31:0]
    output logic [tint_pkg::DW-1:0]             m_tdata,
    output logic                                m_tvalid,
    input  wire  logic                          m_tready,
    input  wire  logic                          cfg_valid,
    output logic                                cfg_ready,
    input  wire  logic [tint_pkg::CFG_IW-1:0]   cfg_index,
    input  wire  logic [tint_pkg::CFG_DW-1:0]   cfg_data
);

    tint_pkg::cmd_t    cmd;
    tint_pkg::status_t status;

    // Register writes are always accepted and land in the following cycle
    assign cfg_ready = 1'b1;

    tint_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tint_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
